// File: rtl/ips_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types, codes and the fixed small-prime table of the prime sieve.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int OP_W              = 2;
  localparam int BYTE_W            = 8;
  localparam int STEPS_W           = 16;
  localparam int PIU_W             = 7;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int IN_TDATA_W        = 16;
  localparam int OUT_TDATA_W       = 24;
  localparam int PRIME_W           = 11;
  localparam int PRIME_TABLE_DEPTH = 256;
  localparam int SHIFT_CNT_W       = 5;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_SEEK    = 2'd3
  } op_e;

  // what one sweep over the residue memory does
  typedef enum logic [2:0] {
    MD_CLEAR = 3'd0,
    MD_LOAD  = 3'd1,
    MD_ADV   = 3'd2,
    MD_SCAN  = 3'd3,
    MD_JUMP  = 3'd4
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIMES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS     = 2'd1;

  localparam logic [PIU_W-1:0]   PIU_RESET       = 7'd64;
  localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = 16'd1024;

  typedef struct packed {
    logic init;
    logic shift;
    logic add;
  } mod_cmd_t;

  localparam logic [PRIME_W-1:0] PRIME_TABLE [PRIME_TABLE_DEPTH] = '{
    11'd2,    11'd3,    11'd5,    11'd7,    11'd11,   11'd13,   11'd17,   11'd19,
    11'd23,   11'd29,   11'd31,   11'd37,   11'd41,   11'd43,   11'd47,   11'd53,
    11'd59,   11'd61,   11'd67,   11'd71,   11'd73,   11'd79,   11'd83,   11'd89,
    11'd97,   11'd101,  11'd103,  11'd107,  11'd109,  11'd113,  11'd127,  11'd131,
    11'd137,  11'd139,  11'd149,  11'd151,  11'd157,  11'd163,  11'd167,  11'd173,
    11'd179,  11'd181,  11'd191,  11'd193,  11'd197,  11'd199,  11'd211,  11'd223,
    11'd227,  11'd229,  11'd233,  11'd239,  11'd241,  11'd251,  11'd257,  11'd263,
    11'd269,  11'd271,  11'd277,  11'd281,  11'd283,  11'd293,  11'd307,  11'd311,
    11'd313,  11'd317,  11'd331,  11'd337,  11'd347,  11'd349,  11'd353,  11'd359,
    11'd367,  11'd373,  11'd379,  11'd383,  11'd389,  11'd397,  11'd401,  11'd409,
    11'd419,  11'd421,  11'd431,  11'd433,  11'd439,  11'd443,  11'd449,  11'd457,
    11'd461,  11'd463,  11'd467,  11'd479,  11'd487,  11'd491,  11'd499,  11'd503,
    11'd509,  11'd521,  11'd523,  11'd541,  11'd547,  11'd557,  11'd563,  11'd569,
    11'd571,  11'd577,  11'd587,  11'd593,  11'd599,  11'd601,  11'd607,  11'd613,
    11'd617,  11'd619,  11'd631,  11'd641,  11'd643,  11'd647,  11'd653,  11'd659,
    11'd661,  11'd673,  11'd677,  11'd683,  11'd691,  11'd701,  11'd709,  11'd719,
    11'd727,  11'd733,  11'd739,  11'd743,  11'd751,  11'd757,  11'd761,  11'd769,
    11'd773,  11'd787,  11'd797,  11'd809,  11'd811,  11'd821,  11'd823,  11'd827,
    11'd829,  11'd839,  11'd853,  11'd857,  11'd859,  11'd863,  11'd877,  11'd881,
    11'd883,  11'd887,  11'd907,  11'd911,  11'd919,  11'd929,  11'd937,  11'd941,
    11'd947,  11'd953,  11'd967,  11'd971,  11'd977,  11'd983,  11'd991,  11'd997,
    11'd1009, 11'd1013, 11'd1019, 11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049,
    11'd1051, 11'd1061, 11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093, 11'd1097,
    11'd1103, 11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151, 11'd1153, 11'd1163,
    11'd1171, 11'd1181, 11'd1187, 11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223,
    11'd1229, 11'd1231, 11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279, 11'd1283,
    11'd1289, 11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307, 11'd1319, 11'd1321,
    11'd1327, 11'd1361, 11'd1367, 11'd1373, 11'd1381, 11'd1399, 11'd1409, 11'd1423,
    11'd1427, 11'd1429, 11'd1433, 11'd1439, 11'd1447, 11'd1451, 11'd1453, 11'd1459,
    11'd1471, 11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493, 11'd1499, 11'd1511,
    11'd1523, 11'd1531, 11'd1543, 11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571,
    11'd1579, 11'd1583, 11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613, 11'd1619
  };

endpackage

// File: rtl/ips_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ips_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/ips_modunit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_modunit
// Bit-serial modular reducer: acc = init, acc = 2*acc+bit mod p, or acc = acc+addend mod p.
// ----------------------------------------------------------------------------
module ips_modunit import ips_pkg::*; #(
  parameter int W = 9
) (
  input  logic         clk_i,
  input  mod_cmd_t     cmd_i,
  input  logic [W-1:0] init_i,
  input  logic         bit_i,
  input  logic [W-1:0] addend_i,
  input  logic [W-1:0] prime_i,
  output logic [W-1:0] acc_o
);

  logic [W-1:0] acc_q, acc_d;
  logic [W:0]   dbl, sum, p_ext;

  assign p_ext = {1'b0, prime_i};
  assign dbl   = {acc_q, bit_i};
  assign sum   = {1'b0, acc_q} + {1'b0, addend_i};

  // both operands stay below 2p, so one conditional subtract reduces them
  always_comb begin
    acc_d = acc_q;
    priority if (cmd_i.init) begin
      acc_d = init_i;
    end else if (cmd_i.shift) begin
      acc_d = (dbl >= p_ext) ? W'(dbl - p_ext) : W'(dbl);
    end else if (cmd_i.add) begin
      acc_d = (sum >= p_ext) ? W'(sum - p_ext) : W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/incremental_prime_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_prime_sieve
// Residues of a candidate modulo the first NPRIMES primes, kept in a RAM and
// updated by clear, byte load, advance-by-two and seek-survivor sweeps.
// ----------------------------------------------------------------------------
// channel   dir  signals                  content
// s_axis    in   tvalid/tready/tdata[15:0] op, data_byte
// m_axis    out  tvalid/tready/tdata[23:0] survivor, steps, limit_hit
// cfg       in   valid/ready/index/data    0 primes_in_use, 1 max_steps
//
// Each item sweeps every RAM entry through read, modify, write: clear writes
// zero, load shifts the byte in bit by bit, advance adds two, seek scans and
// then advances once per step taken, or jumps by 2*max_steps if even.
// After reset a clearing pass runs with s_axis_tready_o low.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only in its last cycle if that result is still held.
// ----------------------------------------------------------------------------
module incremental_prime_sieve import ips_pkg::*; #(
  parameter int NPRIMES       = 64,
  parameter int RESIDUE_WIDTH = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // op[1:0], data_byte[9:2]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // survivor[0], steps[16:1], limit_hit[17]
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDXW   = (NPRIMES > 1) ? $clog2(NPRIMES) : 1;
  localparam int CW     = ((IDXW > PIU_W) ? IDXW : PIU_W) + 1;
  localparam int JUMP_W = STEPS_W + 1;
  localparam int RW     = RESIDUE_WIDTH;
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(NPRIMES - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_LAT  = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_EVAL = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]             state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [IDXW-1:0]        idx_q, idx_d;
  logic                   seek_q, seek_d;
  logic                   init_q, init_d;
  logic                   any_zero_q, any_zero_d;
  logic                   r0zero_q, r0zero_d;
  logic [STEPS_W-1:0]     steps_q, steps_d;
  logic [SHIFT_CNT_W-1:0] cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [PIU_W-1:0]       piu_q;
  logic [STEPS_W-1:0]     max_steps_q;

  logic [BYTE_W-1:0]      byte_q, byte_d;
  logic [RW-1:0]          prime_q, prime_d;
  logic [RW-1:0]          r_q, r_d;
  logic [JUMP_W-1:0]      sh_q, sh_d;
  logic                   res_surv_q, res_surv_d;
  logic [STEPS_W-1:0]     res_steps_q, res_steps_d;
  logic                   res_limit_q, res_limit_d;
  logic                   out_surv_q, out_surv_d;
  logic [STEPS_W-1:0]     out_steps_q, out_steps_d;
  logic                   out_limit_q, out_limit_d;

  logic                   s_fire;
  logic                   cfg_fire;
  logic                   active;
  logic                   ram_we, ram_re;
  logic [RW-1:0]          ram_rdata;
  logic [RW-1:0]          new_val;
  logic [RW-1:0]          init_val;
  logic [RW-1:0]          addend;
  logic [RW-1:0]          acc;
  logic                   shift_last;
  logic [STEPS_W-1:0]     steps_inc;
  mod_cmd_t               mod_cmd;
  op_e                    in_op;

  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_fire        = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_op           = op_e'(s_axis_tdata_i[OP_W-1:0]);
  assign steps_inc       = steps_q + STEPS_W'(1);

  // entry 0 always takes part; beyond NPRIMES is out of reach of idx anyway
  assign active = (idx_q == '0) || (CW'(idx_q) < CW'(piu_q));

  assign shift_last = (mode_q == MD_LOAD) ? (cnt_q == SHIFT_CNT_W'(BYTE_W - 1))
                                          : (cnt_q == SHIFT_CNT_W'(JUMP_W - 1));

  ips_ram #(
    .WIDTH(RW),
    .DEPTH(NPRIMES)
  ) u_ips_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(new_val),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  ips_modunit #(
    .W(RW)
  ) u_ips_modunit (
    .clk_i   (clk_i),
    .cmd_i   (mod_cmd),
    .init_i  (init_val),
    .bit_i   (sh_q[JUMP_W-1]),
    .addend_i(addend),
    .prime_i (prime_q),
    .acc_o   (acc)
  );

  // each entry is read, modified and written back before the next is read,
  // so RAM accesses never overlap on one entry
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    seek_d      = seek_q;
    init_d      = init_q;
    any_zero_d  = any_zero_q;
    r0zero_d    = r0zero_q;
    steps_d     = steps_q;
    cnt_d       = cnt_q;
    byte_d      = byte_q;
    prime_d     = prime_q;
    r_d         = r_q;
    sh_d        = sh_q;
    res_surv_d  = res_surv_q;
    res_steps_d = res_steps_q;
    res_limit_d = res_limit_q;
    out_valid_d = out_valid_q;
    out_surv_d  = out_surv_q;
    out_steps_d = out_steps_q;
    out_limit_d = out_limit_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    mod_cmd     = '0;
    init_val    = ram_rdata;
    addend      = RW'(2);
    new_val     = acc;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (mode_q)
      MD_CLEAR: new_val = '0;
      MD_SCAN:  new_val = r_q;
      default:  new_val = acc;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          byte_d     = s_axis_tdata_i[OP_W+BYTE_W-1:OP_W];
          seek_d     = 1'b0;
          steps_d    = '0;
          idx_d      = '0;
          any_zero_d = 1'b0;
          state_d    = ST_RD;
          unique case (in_op)
            OP_CLEAR:   mode_d = MD_CLEAR;
            OP_LOAD:    mode_d = MD_LOAD;
            OP_ADVANCE: mode_d = MD_ADV;
            OP_SEEK: begin
              mode_d = MD_SCAN;
              seek_d = 1'b1;
            end
            default:    mode_d = MD_CLEAR;
          endcase
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        prime_d = RW'(PRIME_TABLE[idx_q]);
        state_d = (mode_q == MD_CLEAR) ? ST_WR : ST_LAT;
      end
      ST_LAT: begin
        r_d          = ram_rdata;
        cnt_d        = '0;
        mod_cmd.init = 1'b1;
        init_val     = (mode_q == MD_JUMP) ? '0 : ram_rdata;
        sh_d         = (mode_q == MD_LOAD) ? {byte_q, (JUMP_W - BYTE_W)'(0)}
                                           : {max_steps_q, 1'b0};
        unique case (mode_q)
          MD_LOAD, MD_JUMP: state_d = ST_CALC;
          MD_ADV:           state_d = ST_ADD;
          default:          state_d = ST_WR;
        endcase
      end
      ST_CALC: begin
        mod_cmd.shift = 1'b1;
        sh_d          = sh_q << 1;
        if (shift_last) begin
          state_d = (mode_q == MD_JUMP) ? ST_ADD : ST_WR;
        end else begin
          cnt_d = cnt_q + SHIFT_CNT_W'(1);
        end
      end
      ST_ADD: begin
        mod_cmd.add = 1'b1;
        addend      = (mode_q == MD_JUMP) ? r_q : RW'(2);
        state_d     = ST_WR;
      end
      ST_WR: begin
        ram_we = (mode_q != MD_SCAN);
        if (active && (new_val == '0)) begin
          any_zero_d = 1'b1;
        end
        if (idx_q == '0) begin
          r0zero_d = (new_val == '0);
        end
        if (idx_q == IDX_LAST) begin
          state_d = ST_EVAL;
        end else begin
          idx_d   = idx_q + IDXW'(1);
          state_d = ST_RD;
        end
      end
      ST_EVAL: begin
        idx_d       = '0;
        any_zero_d  = 1'b0;
        res_surv_d  = !any_zero_q;
        res_steps_d = '0;
        res_limit_d = 1'b0;
        state_d     = ST_DONE;
        if (init_q) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          unique case (mode_q)
            MD_SCAN: begin
              if (any_zero_q) begin
                if (r0zero_q) begin
                  // even candidate: jump straight by 2*max_steps
                  mode_d  = MD_JUMP;
                  state_d = ST_RD;
                end else if (max_steps_q == '0) begin
                  res_limit_d = 1'b1;
                end else begin
                  mode_d  = MD_ADV;
                  state_d = ST_RD;
                end
              end
            end
            MD_ADV: begin
              steps_d     = steps_inc;
              res_steps_d = steps_inc;
              res_limit_d = seek_q && any_zero_q;
              if (seek_q && any_zero_q && (steps_inc != max_steps_q)) begin
                state_d = ST_RD;
              end
            end
            MD_JUMP: begin
              res_steps_d = max_steps_q;
              res_limit_d = any_zero_q;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_surv_d  = res_surv_q;
          out_steps_d = res_steps_q;
          out_limit_d = res_limit_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RD;
      mode_q      <= MD_CLEAR;
      idx_q       <= '0;
      seek_q      <= 1'b0;
      init_q      <= 1'b1;
      any_zero_q  <= 1'b0;
      r0zero_q    <= 1'b0;
      steps_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      seek_q      <= seek_d;
      init_q      <= init_d;
      any_zero_q  <= any_zero_d;
      r0zero_q    <= r0zero_d;
      steps_q     <= steps_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q       <= PIU_RESET;
      max_steps_q <= MAX_STEPS_RESET;
    end else if (cfg_fire) begin
      if (cfg_index_i == CFG_PRIMES_IN_USE) begin
        piu_q <= cfg_data_i[PIU_W-1:0];
      end else if (cfg_index_i == CFG_MAX_STEPS) begin
        max_steps_q <= cfg_data_i[STEPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    prime_q     <= prime_d;
    r_q         <= r_d;
    sh_q        <= sh_d;
    res_surv_q  <= res_surv_d;
    res_steps_q <= res_steps_d;
    res_limit_q <= res_limit_d;
    out_surv_q  <= out_surv_d;
    out_steps_q <= out_steps_d;
    out_limit_q <= out_limit_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - STEPS_W - 2)'(0), out_limit_q, out_steps_q,
                            out_surv_q};

endmodule

// File: rtl/ips_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_checker
// Port-level checks of the prime sieve, bound to the top level.
// ----------------------------------------------------------------------------
module ips_checker import ips_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int SURV_BIT  = 0;
  localparam int LIMIT_BIT = STEPS_W + 1;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed or dropped while stalled");

  a_limit_not_surv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[LIMIT_BIT] && m_axis_tdata_o[SURV_BIT]))
    else $error("limit_hit reported together with survivor");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while one is in work");

endmodule

bind incremental_prime_sieve ips_checker u_ips_checker (.*);

// File: sim/incremental_prime_sieve_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_prime_sieve_tb
// Self-checking bench for the small-prime sieve. A local copy of the residue
// table predicts every result at input transfer time; a monitor compares each
// output transfer in order. Directed ops, register extremes, output
// backpressure and three random traffic phases with varied idling.
// ----------------------------------------------------------------------------
module incremental_prime_sieve_tb;
  import ips_pkg::*;

  localparam int          NPRIMES     = 64;
  localparam int          CLK_HALF    = 2;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int          SETTLE_CYC  = 16;
  localparam int          HOLD_CYC    = 3000;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic                survivor;
    logic [STEPS_W-1:0]  steps;
    logic                limit_hit;
  } sieve_result_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i      = '0;

  // predictor state
  int unsigned        small_prime [NPRIMES];
  int unsigned        sieve_residue [NPRIMES];
  logic [PIU_W-1:0]   active_primes = PIU_RESET;
  logic [STEPS_W-1:0] step_limit    = MAX_STEPS_RESET;

  sieve_result_t expected_results[$];
  int unsigned   fail_count     = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int            hold_left      = 0;

  incremental_prime_sieve u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit candidate_survives();
    int unsigned k;
    k = active_primes;
    if (k == 0) k = 1;
    if (k > NPRIMES) k = NPRIMES;
    for (int unsigned i = 0; i < k; i++) begin
      if (sieve_residue[i] == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void bump_residues(input int unsigned amount);
    for (int i = 0; i < NPRIMES; i++) begin
      sieve_residue[i] = (sieve_residue[i] + amount % small_prime[i]) % small_prime[i];
    end
  endfunction

  function automatic sieve_result_t predict_sieve(input op_e op, input logic [7:0] data_byte);
    sieve_result_t r;
    int unsigned   taken;
    r     = '0;
    taken = 0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NPRIMES; i++) sieve_residue[i] = 0;
      end
      OP_LOAD: begin
        for (int i = 0; i < NPRIMES; i++) begin
          sieve_residue[i] = (sieve_residue[i] * 256 + data_byte) % small_prime[i];
        end
      end
      OP_ADVANCE: begin
        bump_residues(2);
        taken = 1;
      end
      default: begin
        if (!candidate_survives() && sieve_residue[0] == 0) begin
          // even candidate: sweeps the full limit
          bump_residues(2 * int'(step_limit));
          taken = step_limit;
        end else begin
          while (!candidate_survives() && taken < step_limit) begin
            bump_residues(2);
            taken++;
          end
        end
        r.limit_hit = !candidate_survives();
      end
    endcase
    r.steps    = taken[STEPS_W-1:0];
    r.survivor = candidate_survives();
    return r;
  endfunction

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : check_results
    sieve_result_t got;
    sieve_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.survivor  = m_axis_tdata_o[0];
      got.steps     = m_axis_tdata_o[16:1];
      got.limit_hit = m_axis_tdata_o[17];
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: surv=%0d steps=%0d limit=%0d",
                   got.survivor, got.steps, got.limit_hit);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: exp surv=%0d steps=%0d limit=%0d, got surv=%0d steps=%0d limit=%0d",
                     want.survivor, want.steps, want.limit_hit,
                     got.survivor, got.steps, got.limit_hit);
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input op_e op, input logic [7:0] data_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, data_byte, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(predict_sieve(op, data_byte));
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PRIMES_IN_USE) active_primes = value[PIU_W-1:0];
    else if (idx == CFG_MAX_STEPS) step_limit = value;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    send_item(OP_SEEK, 8'h00);     // zero candidate is even
    send_item(OP_ADVANCE, 8'hFF);
    send_item(OP_CLEAR, 8'hA5);
  endtask

  task automatic test_load_extremes();
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'h00);
    send_item(OP_LOAD, 8'h01);
    send_item(OP_SEEK, 8'h00);
    send_item(OP_SEEK, 8'h00);     // survivor already there
    send_item(OP_ADVANCE, 8'h00);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_PRIMES_IN_USE, '0);   // behaves as one prime
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_LOAD, 8'h07);
    send_item(OP_SEEK, 8'h00);
    send_item(OP_LOAD, 8'h02);
    write_reg(CFG_MAX_STEPS, '0);
    send_item(OP_SEEK, 8'h00);
    write_reg(CFG_MAX_STEPS, 16'hFFFF);
    send_item(OP_SEEK, 8'h00);
    write_reg(CFG_PRIMES_IN_USE, 16'hFFFF);  // 127, clamps to table size
    write_reg(2'd2, 16'h0000);
    write_reg(2'd3, 16'hFFFF);
    write_reg(CFG_MAX_STEPS, 16'd1);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_LOAD, 8'h09);
    send_item(OP_SEEK, 8'h00);
    send_item(OP_ADVANCE, 8'h00);
    write_reg(CFG_PRIMES_IN_USE, 16'h0140);  // upper bits dropped -> 64
    write_reg(CFG_MAX_STEPS, MAX_STEPS_RESET);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    recv_stall_pct = 0;
    send_idle_pct  = 0;
    @(negedge clk_i);
    hold_left = HOLD_CYC;
    @(posedge clk_i);
    send_item(OP_LOAD, 8'h3D);
    send_item(OP_LOAD, 8'hC2);
    send_item(OP_LOAD, 8'h5B);
    send_item(OP_SEEK, 8'h00);
  endtask

  task automatic run_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned sent;
    int unsigned n_bytes;
    int unsigned n_tail;
    logic [7:0]  b;
    logic [1:0]  raw_op;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(1) == 1) begin
          send_item(OP_CLEAR, 8'($urandom));
          sent++;
        end
        n_bytes = $urandom_range(4, 1);
        for (int j = 0; j < n_bytes; j++) begin
          b = 8'($urandom);
          if (j == n_bytes - 1 && $urandom_range(9) < 7) b[0] = 1'b1;
          send_item(OP_LOAD, b);
          sent++;
        end
        n_tail = $urandom_range(3, 1);
        repeat (n_tail) begin
          send_item(($urandom_range(9) < 7) ? OP_SEEK : OP_ADVANCE, 8'($urandom));
          sent++;
        end
      end else begin
        raw_op = 2'($urandom_range(3));
        send_item(op_e'(raw_op), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    // first 64 primes, by trial division
    begin : fill_primes
      int unsigned found;
      int unsigned cand;
      bit          prime;
      found = 0;
      cand  = 2;
      while (found < NPRIMES) begin
        prime = 1'b1;
        for (int unsigned d = 2; d * d <= cand; d++) begin
          if (cand % d == 0) prime = 1'b0;
        end
        if (prime) begin
          small_prime[found] = cand;
          found++;
        end
        cand++;
      end
    end
    for (int i = 0; i < NPRIMES; i++) sieve_residue[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_load_extremes();
    test_register_extremes();
    test_output_backpressure();

    write_reg(CFG_PRIMES_IN_USE, 16'd64);
    write_reg(CFG_MAX_STEPS, 16'd1024);
    run_random_traffic(150, 37, 73);

    write_reg(CFG_PRIMES_IN_USE, 16'($urandom_range(40, 2)));
    write_reg(CFG_MAX_STEPS, 16'($urandom_range(6, 1)));
    run_random_traffic(150, 73, 37);

    write_reg(CFG_PRIMES_IN_USE, 16'd64);
    write_reg(CFG_MAX_STEPS, 16'hFFFF);
    run_random_traffic(150, 0, 0);

    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
